// ----- rtl/core/ffaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_pkg: shared types and constants of the first-fit arena allocator
// Granule geometry, the block header layout, codes and the sequencer states.
// ----------------------------------------------------------------------------
package ffaa_pkg;

	// arena geometry
	localparam int ARENA_MAX_BYTES = 65536;
	localparam int GRANULE_BYTES   = 16;
	localparam int HEADER_BYTES    = 48;
	localparam int GSH   = $clog2(GRANULE_BYTES);
	localparam int HDR_G = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
	localparam int HDR_BYTES = HDR_G * GRANULE_BYTES;
	localparam int MIN_G = HDR_G + 1;
	localparam int NG    = ARENA_MAX_BYTES / GRANULE_BYTES;
	localparam int GW    = $clog2(NG);
	localparam int CW    = GW + 1;
	localparam int BW    = 17;

	// opcodes
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_RESIZE  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef logic [GW-1:0] gidx_t;
	typedef logic [CW-1:0] gcnt_t;

	// block header as kept in the header RAM (prev link lives in its own RAM)
	typedef struct packed {
		logic          vld;
		gidx_t         len;
		gidx_t         nxt;
		logic [BW-1:0] req;
		logic          hp;
		logic          hn;
		logic          fr;
	} hdr_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_EV,
		S_LOC_RD,
		S_LOC_EV,
		S_REL,
		S_RN_EV,
		S_RP,
		S_RP_EV,
		S_RWB,
		S_RZ,
		S_RZN_EV,
		S_RZ_DEC,
		S_CUT,
		S_CN_EV,
		S_CWR,
		S_CSUCC,
		S_CUT_DONE,
		S_FIN
	} state_t;

endpackage

// ----- rtl/core/ffaa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/first_fit_arena_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator: first-fit boundary-tag allocator, headers only
// Allocate, release and resize over a chain of block headers held in RAM.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_*       in   tuser: mode; tdata: request_bytes, handle
//  m_*       out  tuser: moved; tdata: status, result_handle, copy_from,
//                 copy_bytes, used_bytes, peak_bytes
//  cfg_*     in   arena_bytes write, reformats the arena
//
//  Release locates the header, merges free neighbours and writes back; a
//  null release, an unused mode or a malformed handle skips to the result.
//  Allocate walks the first-fit chain, a read and an evaluate state per
//  block visited, then accepts, splits and writes the result; the header RAM
//  read latency sets the walk step. A resize that relocates adds a walk and
//  a release. After reset and after every arena_bytes write the header RAM
//  is cleared entry by entry, s_tready low. One beat is in work at a time; a
//  finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator
	import ffaa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [BW-1:0] cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,  // request_bytes[16:0], handle[33:17], zero
	input  logic [1:0]    s_tuser,  // mode[1:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [87:0]   m_tdata,  // status[1:0], result_handle[18:2],
	                                // copy_from[35:19], copy_bytes[52:36],
	                                // used_bytes[69:53], peak_bytes[86:70], zero
	output logic [0:0]    m_tuser   // moved
);

	state_t st_q, st_d;
	gidx_t  clr_q;
	gcnt_t  cap_q;

	logic [1:0]    mode_q;
	logic [BW-1:0] req_q, h_q, oldreq_q;
	gcnt_t         want_q, used_q, peak_q;
	gidx_t         boff_q, bprev_q, ooff_q, roff_q, oldlen_q;
	hdr_t          b_q, r_q;
	logic          mv_q, shr_q, pm_q;

	logic [1:0]    f_status_q;
	logic [BW-1:0] f_res_q, f_from_q, f_copy_q;
	logic          f_mv_q;

	logic          m_tvalid_q;
	logic [1:0]    o_status_q;
	logic [BW-1:0] o_res_q, o_from_q, o_copy_q, o_used_q, o_peak_q;
	logic          o_mv_q;

	// RAM ports
	logic  hw_we, pw_we;
	gidx_t hw_addr, pw_addr, pw_data, rd_addr;
	hdr_t  hw_data, rdh;
	gidx_t rdp;

	ffaa_ram #(.WIDTH($bits(hdr_t)), .DEPTH(NG)) u_hdr_ram (
		.clk   (clk),
		.we    (hw_we),
		.waddr (hw_addr),
		.wdata (hw_data),
		.raddr (rd_addr),
		.rdata (rdh)
	);

	ffaa_ram #(.WIDTH(GW), .DEPTH(NG)) u_prev_ram (
		.clk   (clk),
		.we    (pw_we),
		.waddr (pw_addr),
		.wdata (pw_data),
		.raddr (rd_addr),
		.rdata (rdp)
	);

	// input beat decode
	logic [1:0]    in_mode;
	logic [BW-1:0] in_req, in_h, in_rq1, in_hs;
	logic [BW:0]   in_sum;
	gcnt_t         in_want, in_og;
	logic          in_bad;

	assign in_mode = s_tuser;
	assign in_req  = s_tdata[BW-1:0];
	assign in_h    = s_tdata[2*BW-1:BW];
	assign in_rq1  = (in_req == '0) ? BW'(1) : in_req;
	assign in_sum  = {1'b0, in_rq1} + (BW+1)'(GRANULE_BYTES - 1);
	// requests at the top of the field saturate so they never fit
	assign in_want = in_sum[BW] ? '1 : in_sum[GSH +: CW];
	assign in_hs   = in_h - BW'(HDR_BYTES);
	assign in_og   = in_hs[GSH +: CW];
	assign in_bad  = (in_h < BW'(HDR_BYTES)) || (in_hs[GSH-1:0] != '0) || (in_og >= cap_q);

	// arena size from a register write
	logic [BW-1:0] cfg_cl;
	gcnt_t         cfg_g, cfg_cap;

	assign cfg_cl  = (cfg_wdata > BW'(ARENA_MAX_BYTES)) ? BW'(ARENA_MAX_BYTES) : cfg_wdata;
	assign cfg_g   = cfg_cl[GSH +: CW];
	assign cfg_cap = (cfg_g < CW'(MIN_G)) ? CW'(MIN_G) : cfg_g;

	// shared length unit and compares
	gcnt_t b_len, mrg_a, mrg_len, sz_b, nu_used;
	logic  rd_fit, cut_ok, grow;

	assign b_len   = {1'b0, b_q.len};
	assign mrg_a   = (st_q == S_CN_EV) ? {1'b0, r_q.len} : b_len;
	assign mrg_len = mrg_a + CW'(HDR_G) + {1'b0, rdh.len};
	assign sz_b    = b_len + CW'(HDR_G);
	assign rd_fit  = rdh.fr && ({1'b0, rdh.len} >= want_q);
	assign cut_ok  = (want_q <= b_len) && ((b_len - want_q) >= CW'(MIN_G));
	assign grow    = rdh.fr && ((CW'(HDR_G) + {1'b0, rdh.len}) >= (want_q - b_len));
	assign nu_used = shr_q ? (used_q - {1'b0, oldlen_q} + b_len) : (used_q + sz_b);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_CLEAR: begin
				if (clr_q == GW'(NG - 1)) st_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					case (in_mode)
						MODE_ALLOC:   st_d = S_WALK_RD;
						MODE_RELEASE: st_d = (in_h == '0 || in_bad) ? S_FIN : S_LOC_RD;
						MODE_RESIZE: begin
							if (in_h == '0) st_d = S_WALK_RD;
							else st_d = in_bad ? S_FIN : S_LOC_RD;
						end
						default:      st_d = S_FIN;
					endcase
				end
			end
			S_WALK_RD:  st_d = ({1'b0, boff_q} >= cap_q) ? S_FIN : S_WALK_EV;
			S_WALK_EV: begin
				if (!rdh.vld) st_d = S_FIN;
				else if (rd_fit) st_d = S_CUT;
				else if (!rdh.hn || rdh.nxt <= boff_q) st_d = S_FIN;
				else st_d = S_WALK_RD;
			end
			S_LOC_RD:   st_d = S_LOC_EV;
			S_LOC_EV: begin
				if (mv_q) st_d = S_REL;
				else if (!rdh.vld || rdh.fr) st_d = S_FIN;
				else if (mode_q == MODE_RELEASE || req_q == '0) st_d = S_REL;
				else st_d = S_RZ;
			end
			S_REL:      st_d = b_q.hn ? S_RN_EV : S_RP;
			S_RN_EV:    st_d = S_RP;
			S_RP:       st_d = b_q.hp ? S_RP_EV : S_RWB;
			S_RP_EV:    st_d = S_RWB;
			S_RWB:      st_d = S_FIN;
			S_RZ:       st_d = (want_q > b_len && b_q.hn) ? S_RZN_EV : S_RZ_DEC;
			S_RZN_EV:   st_d = S_RZ_DEC;
			S_RZ_DEC:   st_d = (want_q <= b_len) ? S_CUT : S_WALK_RD;
			S_CUT: begin
				if (!cut_ok) st_d = S_CUT_DONE;
				else st_d = b_q.hn ? S_CN_EV : S_CWR;
			end
			S_CN_EV:    st_d = S_CWR;
			S_CWR:      st_d = r_q.hn ? S_CSUCC : S_CUT_DONE;
			S_CSUCC:    st_d = S_CUT_DONE;
			S_CUT_DONE: st_d = (mv_q && !shr_q) ? S_LOC_RD : S_FIN;
			S_FIN:      st_d = (!m_tvalid_q || m_tready) ? S_IDLE : S_FIN;
			default:    st_d = S_IDLE;
		endcase
	end

	// RAM control and handshake outputs
	always_comb begin
		s_tready = 1'b0;
		rd_addr  = boff_q;
		hw_we    = 1'b0;
		hw_addr  = boff_q;
		hw_data  = b_q;
		pw_we    = 1'b0;
		pw_addr  = b_q.nxt;
		pw_data  = boff_q;
		case (st_q)
			S_CLEAR: begin
				hw_we   = 1'b1;
				hw_addr = clr_q;
				hw_data = '0;
				if (clr_q == '0) begin
					hw_data.vld = 1'b1;
					hw_data.len = GW'(cap_q - CW'(HDR_G));
					hw_data.fr  = 1'b1;
				end
			end
			S_IDLE:    s_tready = 1'b1;
			S_REL:     rd_addr = b_q.nxt;
			S_RN_EV: begin
				hw_we   = rdh.fr;
				hw_addr = b_q.nxt;
				hw_data = rdh;
				hw_data.vld = 1'b0;
			end
			S_RP:      rd_addr = bprev_q;
			S_RP_EV: begin
				hw_we   = rdh.fr;
				hw_addr = bprev_q;
				hw_data = rdh;
				hw_data.len = mrg_len[GW-1:0];
				hw_data.nxt = b_q.nxt;
				hw_data.hn  = b_q.hn;
			end
			S_RWB: begin
				hw_we = 1'b1;
				hw_data.vld = !pm_q;
				pw_we   = b_q.hn;
				pw_data = pm_q ? bprev_q : boff_q;
			end
			S_RZ:      rd_addr = b_q.nxt;
			S_RZN_EV: begin
				hw_we   = grow;
				hw_addr = b_q.nxt;
				hw_data = rdh;
				hw_data.vld = 1'b0;
				pw_we   = grow && rdh.hn;
				pw_addr = rdh.nxt;
			end
			S_CUT:     rd_addr = b_q.nxt;
			S_CN_EV: begin
				hw_we   = rdh.fr;
				hw_addr = r_q.nxt;
				hw_data = rdh;
				hw_data.vld = 1'b0;
			end
			S_CWR: begin
				hw_we   = 1'b1;
				hw_addr = roff_q;
				hw_data = r_q;
				pw_we   = 1'b1;
				pw_addr = roff_q;
			end
			S_CSUCC: begin
				pw_we   = 1'b1;
				pw_addr = r_q.nxt;
				pw_data = roff_q;
			end
			S_CUT_DONE: begin
				hw_we = 1'b1;
				hw_data.fr  = 1'b0;
				hw_data.req = req_q;
			end
			default: ;
		endcase
	end

	// sequencer state and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLEAR;
			clr_q  <= '0;
			cap_q  <= CW'(NG);
			used_q <= '0;
			peak_q <= '0;
		end else if (cfg_we) begin
			st_q   <= S_CLEAR;
			clr_q  <= '0;
			cap_q  <= cfg_cap;
			used_q <= '0;
			peak_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == S_CLEAR) clr_q <= clr_q + GW'(1);
			case (st_q)
				S_REL: used_q <= (used_q >= sz_b) ? (used_q - sz_b) : '0;
				S_CUT_DONE: begin
					used_q <= nu_used;
					if (nu_used > peak_q) peak_q <= nu_used;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (s_tvalid) begin
					mode_q     <= in_mode;
					req_q      <= in_req;
					h_q        <= in_h;
					want_q     <= in_want;
					mv_q       <= 1'b0;
					shr_q      <= 1'b0;
					pm_q       <= 1'b0;
					f_res_q    <= '0;
					f_mv_q     <= 1'b0;
					f_from_q   <= '0;
					f_copy_q   <= '0;
					boff_q     <= (in_mode == MODE_ALLOC || in_h == '0) ? '0 : in_og[GW-1:0];
					f_status_q <= ST_OK;
					if (in_mode != MODE_ALLOC && in_mode != MODE_RELEASE
						&& in_mode != MODE_RESIZE) begin
						f_status_q <= ST_INVALID;
					end else if (in_mode != MODE_ALLOC && in_h != '0 && in_bad) begin
						f_status_q <= ST_INVALID;
					end
				end
			end
			S_WALK_RD: begin
				if ({1'b0, boff_q} >= cap_q) f_status_q <= ST_INVALID;
			end
			S_WALK_EV: begin
				b_q     <= rdh;
				bprev_q <= rdp;
				if (!rdh.vld) f_status_q <= ST_INVALID;
				else if (rd_fit) f_status_q <= ST_OK;
				else if (!rdh.hn) f_status_q <= ST_NOSPACE;
				else if (rdh.nxt <= boff_q) f_status_q <= ST_INVALID;
				else boff_q <= rdh.nxt;
			end
			S_LOC_EV: begin
				b_q     <= rdh;
				bprev_q <= rdp;
				if (!mv_q) begin
					oldlen_q <= rdh.len;
					oldreq_q <= rdh.req;
					ooff_q   <= boff_q;
					if (!rdh.vld || rdh.fr) f_status_q <= ST_INVALID;
				end
			end
			S_REL: begin
				b_q.fr  <= 1'b1;
				b_q.req <= '0;
			end
			S_RN_EV, S_RZN_EV: begin
				if ((st_q == S_RN_EV) ? rdh.fr : grow) begin
					b_q.len <= mrg_len[GW-1:0];
					b_q.hn  <= rdh.hn;
					b_q.nxt <= rdh.nxt;
				end
			end
			S_RP_EV:  pm_q <= rdh.fr;
			S_RWB: begin
				if (mv_q) begin
					f_mv_q   <= 1'b1;
					f_from_q <= h_q;
					f_copy_q <= (oldreq_q < req_q) ? oldreq_q : req_q;
				end
			end
			S_RZ_DEC: begin
				if (want_q <= b_len) begin
					shr_q <= 1'b1;
				end else begin
					mv_q   <= 1'b1;
					boff_q <= '0;
				end
			end
			S_CUT: begin
				if (cut_ok) begin
					roff_q    <= GW'({1'b0, boff_q} + CW'(HDR_G) + want_q);
					r_q.vld   <= 1'b1;
					r_q.len   <= GW'(b_len - want_q - CW'(HDR_G));
					r_q.nxt   <= b_q.nxt;
					r_q.req   <= '0;
					r_q.hp    <= 1'b1;
					r_q.hn    <= b_q.hn;
					r_q.fr    <= 1'b1;
					b_q.len   <= want_q[GW-1:0];
					b_q.nxt   <= GW'({1'b0, boff_q} + CW'(HDR_G) + want_q);
					b_q.hn    <= 1'b1;
				end
			end
			S_CN_EV: begin
				if (rdh.fr) begin
					r_q.len <= mrg_len[GW-1:0];
					r_q.hn  <= rdh.hn;
					r_q.nxt <= rdh.nxt;
				end
			end
			S_CUT_DONE: begin
				if (shr_q) begin
					f_res_q <= h_q;
				end else begin
					f_res_q <= {CW'({1'b0, boff_q} + CW'(HDR_G)), {GSH{1'b0}}};
					if (mv_q) boff_q <= ooff_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (st_q == S_FIN && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FIN && (!m_tvalid_q || m_tready)) begin
			o_status_q <= f_status_q;
			o_res_q    <= (f_status_q == ST_OK) ? f_res_q : '0;
			o_mv_q     <= f_mv_q;
			o_from_q   <= f_from_q;
			o_copy_q   <= f_copy_q;
			o_used_q   <= {used_q, {GSH{1'b0}}};
			o_peak_q   <= {peak_q, {GSH{1'b0}}};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_mv_q;
	assign m_tdata  = {1'b0, o_peak_q, o_used_q, o_copy_q, o_from_q, o_res_q, o_status_q};

`ifndef SYNTH
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= cap_q) else $error("used count beyond arena");
	a_peak_used: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q) else $error("peak below used count");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second beat taken while busy");
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[18:2] == '0 && m_tuser == 1'b0)
		else $error("failed result carries a handle");
	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLEAR |-> hw_we && !s_tready) else $error("clearing pass stalled");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the first-fit arena allocator
// Drives allocate, release and resize beats with random idling on both sides.
// An in-bench model of the header chain predicts each result beat, which is
// compared field by field. The arena size is rewritten between phases.
// ----------------------------------------------------------------------------
module tb
	import ffaa_pkg::*;
();

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HB    = 48;            // header bytes, whole granules
	localparam int GB    = 16;
	localparam int NGR   = 4096;
	localparam int LIMIT = 4000000;

	typedef struct {
		logic [1:0]  st;
		logic [16:0] res;
		logic        mv;
		logic [16:0] from;
		logic [16:0] copy;
		logic [16:0] used;
		logic [16:0] peak;
	} alloc_result_t;

	// header chain model plus queue of predicted result beats
	class arena_board;
		int unsigned len[NGR], prv[NGR], nxt[NGR], rq[NGR];
		bit hp[NGR], hn[NGR], fr[NGR], vld[NGR];
		int unsigned cap, used, peak;
		alloc_result_t pending[$];
		int unsigned live[$], dead[$];
		int errors;

		function int unsigned gi(int unsigned off);
			return (off / GB) % NGR;
		endfunction

		function void format(int unsigned a);
			int unsigned v;
			v = (a > 65536) ? 65536 : a;
			v = v / GB * GB;
			if (v < HB + GB) v = HB + GB;
			cap = v;
			foreach (len[i]) begin
				len[i] = 0; prv[i] = 0; nxt[i] = 0; rq[i] = 0;
				hp[i] = 0; hn[i] = 0; fr[i] = 0; vld[i] = 0;
			end
			len[0] = cap - HB;
			fr[0] = 1;
			vld[0] = 1;
			used = 0;
			peak = 0;
			live.delete();
			dead.delete();
		endfunction

		function void join_next(int unsigned off);
			int unsigned b, n;
			b = gi(off);
			if (!hn[b]) return;
			n = gi(nxt[b]);
			if (!fr[n]) return;
			len[b] += HB + len[n];
			vld[n] = 0;
			hn[b] = hn[n];
			nxt[b] = nxt[n];
			if (hn[b]) prv[gi(nxt[b])] = off;
		endfunction

		function void split(int unsigned off, int unsigned wanted);
			int unsigned b, roff, r;
			b = gi(off);
			if (wanted > len[b] || len[b] - wanted < HB + GB) return;
			roff = off + HB + wanted;
			r = gi(roff);
			len[r] = len[b] - wanted - HB;
			prv[r] = off;
			hp[r] = 1;
			nxt[r] = nxt[b];
			hn[r] = hn[b];
			rq[r] = 0;
			fr[r] = 1;
			vld[r] = 1;
			if (hn[b]) prv[gi(nxt[b])] = roff;
			len[b] = wanted;
			nxt[b] = roff;
			hn[b] = 1;
			join_next(roff);
		endfunction

		function logic [1:0] first_fit(int unsigned req, output int unsigned res);
			int unsigned wanted, off, b;
			wanted = ((req ? req : 1) + GB - 1) / GB * GB;
			off = 0;
			res = 0;
			for (int n = 0; n < NGR; n++) begin
				if (off >= cap || !vld[gi(off)]) return ST_INVALID;
				b = gi(off);
				if (fr[b] && len[b] >= wanted) begin
					split(off, wanted);
					fr[b] = 0;
					rq[b] = req;
					used += HB + len[b];
					if (used > peak) peak = used;
					res = off + HB;
					return ST_OK;
				end
				if (!hn[b]) return ST_NOSPACE;
				if (nxt[b] <= off) return ST_INVALID;
				off = nxt[b];
			end
			return ST_INVALID;
		endfunction

		function bit find_block(int unsigned h, output int unsigned off);
			int unsigned o;
			off = 0;
			if (h < HB) return 0;
			o = h - HB;
			if (o % GB != 0 || o >= cap) return 0;
			if (!vld[gi(o)] || fr[gi(o)]) return 0;
			off = o;
			return 1;
		endfunction

		function void give_back(int unsigned off);
			int unsigned b, sz;
			b = gi(off);
			sz = HB + len[b];
			used = (used >= sz) ? used - sz : 0;
			fr[b] = 1;
			rq[b] = 0;
			join_next(off);
			if (hp[b] && fr[gi(prv[b])]) join_next(prv[b]);
		endfunction

		function void drop_live(int unsigned h);
			foreach (live[i]) if (live[i] == h) begin
				live.delete(i);
				break;
			end
			dead.push_back(h);
			if (dead.size() > 32) void'(dead.pop_front());
		endfunction

		// accepted input beat: update the model and queue the expected result
		function void note_input(logic [1:0] mode, int unsigned req, int unsigned h);
			alloc_result_t e;
			int unsigned off, b, old_len, wanted, oldreq, res;
			e = '{default: 0};
			res = 0;
			if (mode == MODE_ALLOC) begin
				e.st = first_fit(req, res);
				if (e.st == ST_OK) live.push_back(res);
			end else if (mode == MODE_RELEASE) begin
				if (h != 0) begin
					if (find_block(h, off)) begin
						give_back(off);
						drop_live(h);
					end else e.st = ST_INVALID;
				end
			end else if (mode == MODE_RESIZE) begin
				if (h == 0) begin
					e.st = first_fit(req, res);
					if (e.st == ST_OK) live.push_back(res);
				end else if (!find_block(h, off)) begin
					e.st = ST_INVALID;
				end else if (req == 0) begin
					give_back(off);
					drop_live(h);
				end else begin
					b = gi(off);
					old_len = len[b];
					wanted = (req + GB - 1) / GB * GB;
					if (wanted > len[b] && hn[b]) begin
						if (fr[gi(nxt[b])] && HB + len[gi(nxt[b])] >= wanted - len[b])
							join_next(off);
					end
					if (wanted <= len[b]) begin
						split(off, wanted);
						used = used - old_len + len[b];
						if (used > peak) peak = used;
						rq[b] = req;
						res = h;
					end else begin
						oldreq = rq[b];
						e.st = first_fit(req, res);
						if (e.st == ST_OK) begin
							e.mv = 1;
							e.from = h;
							e.copy = (oldreq < req) ? oldreq : req;
							give_back(off);
							drop_live(h);
							live.push_back(res);
						end
					end
				end
			end else begin
				e.st = ST_INVALID;
			end
			if (e.st != ST_OK) res = 0;
			e.res = res;
			e.used = used;
			e.peak = peak;
			pending.push_back(e);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		// accepted result beat against the oldest expectation
		task check(logic [87:0] d, logic mv);
			alloc_result_t e;
			if (pending.size() == 0) begin
				report("unexpected beat", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (d[1:0]   != e.st)   report("status", d[1:0], e.st);
			if (d[18:2]  != e.res)  report("result_handle", d[18:2], e.res);
			if (mv       != e.mv)   report("moved", mv, e.mv);
			if (d[35:19] != e.from) report("copy_from", d[35:19], e.from);
			if (d[52:36] != e.copy) report("copy_bytes", d[52:36], e.copy);
			if (d[69:53] != e.used) report("used_bytes", d[69:53], e.used);
			if (d[86:70] != e.peak) report("peak_bytes", d[86:70], e.peak);
		endtask
	endclass

	logic          clk, arst_n, cfg_we;
	logic [BW-1:0] cfg_wdata;
	logic          s_tvalid, s_tready, m_tvalid, m_tready;
	logic [39:0]   s_tdata;
	logic [1:0]    s_tuser;
	logic [87:0]   m_tdata;
	logic [0:0]    m_tuser;

	arena_board board;
	int n_in;
	bit calm, held;
	int unsigned cyc = 0;

	first_fit_arena_allocator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, one long hold once the input is flowing
	initial begin
		m_tready = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && n_in >= 150) begin
				held = 1;
				m_tready <= 0;
				repeat (400) @(negedge clk);
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 19);
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready) board.check(m_tdata, m_tuser[0]);

	// one input beat, called at a falling edge, returns at a falling edge
	task send(logic [1:0] mode, int unsigned req, int unsigned h);
		while (!calm && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= mode;
		s_tdata  <= {6'b0, h[16:0], req[16:0]};
		do @(posedge clk); while (!s_tready);
		board.note_input(mode, req[16:0], h[16:0]);
		n_in++;
		@(negedge clk);
	endtask

	task drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task set_arena(int unsigned a);
		cfg_we    <= 1;
		cfg_wdata <= a[16:0];
		@(negedge clk);
		cfg_we <= 0;
		board.format(a);
	endtask

	function int unsigned pick_live();
		if (board.live.size() == 0) return 0;
		return board.live[$urandom_range(0, board.live.size() - 1)];
	endfunction

	// handles that are likely to be refused, or null
	function int unsigned odd_handle();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, HB - 1);
			1: return pick_live() + $urandom_range(1, 15);
			2: return $urandom_range(0, 17'h1ffff);
			3: return board.dead.size() ? board.dead[$urandom_range(0, board.dead.size()-1)] : 0;
			4: return board.cap + HB + GB * $urandom_range(0, 4);
			default: return 0;
		endcase
	endfunction

	function int unsigned rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(0, 200);
		if (r < 96) return $urandom_range(0, 3000);
		return $urandom_range(0, 17'h1ffff);
	endfunction

	task random_beat();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) send(MODE_ALLOC, rand_size(), $urandom_range(0, 17'h1ffff));
		else if (r < 63)
			send(MODE_RELEASE, $urandom_range(0, 17'h1ffff),
				($urandom_range(0, 9) < 8) ? pick_live() : odd_handle());
		else if (r < 93)
			send(MODE_RESIZE, ($urandom_range(0, 19) == 0) ? 0 : rand_size(),
				($urandom_range(0, 9) < 8) ? pick_live() : odd_handle());
		else
			send(MODE_UNUSED, $urandom_range(0, 17'h1ffff), $urandom_range(0, 17'h1ffff));
	endtask

	int unsigned arenas[7] = '{65536, 64, 1000, 17'h1ffff, 0, 4096, 2000};
	int unsigned h1, h2;

	initial begin
		board = new();
		board.format(65536);
		arst_n = 0; cfg_we = 0; cfg_wdata = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		n_in = 0; calm = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;

		// directed: edges of sizes and handles, every mode, every refusal
		send(MODE_ALLOC, 0, 0);
		send(MODE_ALLOC, 1, 0);
		send(MODE_ALLOC, 16, 0);
		send(MODE_ALLOC, 17, 0);
		send(MODE_ALLOC, 17'h1ffff, 0);
		send(MODE_ALLOC, 65536 - HB, 0);
		h1 = pick_live();
		send(MODE_RELEASE, 0, 0);
		send(MODE_RELEASE, 0, 5);
		send(MODE_RELEASE, 0, HB + 1);
		send(MODE_RELEASE, 0, 17'h1ffff);
		send(MODE_RELEASE, 0, h1);
		send(MODE_RELEASE, 0, h1);
		send(MODE_RESIZE, 32, 0);
		h2 = pick_live();
		send(MODE_RESIZE, 0, h2);
		h2 = pick_live();
		send(MODE_RESIZE, 40, h2);
		send(MODE_RESIZE, 500, h2);
		send(MODE_RESIZE, 16, h2);
		send(MODE_RESIZE, 17'h1ffff, h2);
		send(MODE_RESIZE, 5000, board.live[0]);
		send(MODE_UNUSED, 17'h1ffff, 17'h1ffff);
		send(MODE_ALLOC, 65536 - 2 * HB - 2000, 0);
		send(MODE_RESIZE, 60000, board.live[0]);

		foreach (arenas[p]) begin
			if (p > 0) begin
				drain();
				set_arena(arenas[p]);
			end
			for (int i = 0; i < 200; i++) begin
				calm = (n_in >= 600 && n_in < 760);
				random_beat();
			end
		end
		calm = 0;
		drain();
		if (board.errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

// ----- first_fit_arena_allocator.f -----
rtl/core/ffaa_pkg.sv
rtl/core/ffaa_ram.sv
rtl/core/first_fit_arena_allocator.sv
tb/sv/tb.sv
